// ----- src/pffi_pkg.sv -----
// Package: shared types, constants and fixed-point helpers of the particle integrator.
`timescale 1ns / 1ps

package pffi_pkg;

  // Table sizes and the widths that follow from them
  localparam int MAX_PARTICLES = 64;
  localparam int MAX_FIELDS    = 8;
  localparam int P_IDX_W       = $clog2(MAX_PARTICLES);
  localparam int P_CNT_W       = $clog2(MAX_PARTICLES + 1);
  localparam int F_IDX_W       = $clog2(MAX_FIELDS);
  localparam int F_CNT_W       = $clog2(MAX_FIELDS + 1);
  localparam int SLOT_W        = 6;

  // Fields whose squared distance is at most 0.01 (Q32.32) are skipped
  localparam logic [63:0] R2_LIMIT = 64'd42949672;

  // Reset values: 9.81 for the energy term, built-in field at (0, -1000, 0)
  localparam logic signed [31:0] RESET_GRAVITY = 32'sd642908;
  localparam logic signed [31:0] FLD0_STRENGTH = -32'sd642908;
  localparam logic signed [31:0] FLD0_CENTER_Y = -32'sd65536000;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ADD_PART  = 2'd0,
    REQ_ADD_FIELD = 2'd1,
    REQ_STEP      = 2'd2,
    REQ_ENERGY    = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_MASS   = 2'd2,
    STAT_PAUSED = 2'd3
  } status_t;

  // Field kinds; other codes are inert
  localparam logic [1:0] KIND_GRAVITY = 2'd0;
  localparam logic [1:0] KIND_EM      = 2'd1;

  // Configuration register indexes
  localparam logic CFG_GRAVITY = 1'b0;
  localparam logic CFG_PAUSED  = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [1:0]       field_kind;
    logic [2:0][31:0] coord;
    logic [31:0]      mass;
    logic [31:0]      charge;
    logic [31:0]      strength;
    logic [31:0]      dt;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [63:0]       total;
    logic [1:0]        status;
  } result_t;

  typedef struct packed {
    logic [31:0] gravity;
    logic        paused;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [31:0]      mass;
    logic [31:0]      charge;
  } p_entry_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      strength;
    logic [2:0][31:0] center;
  } f_entry_t;

  localparam f_entry_t FLD0_ENTRY = '{
    kind:     KIND_GRAVITY,
    strength: FLD0_STRENGTH,
    center:   {32'd0, FLD0_CENTER_Y, 32'd0}
  };

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    return sat32(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

  // Divide by 65536, truncating toward zero
  function automatic logic signed [63:0] div_q16(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + (v[63] ? 64'sd65535 : 64'sd0);
    return b >>> 16;
  endfunction

  // Q16.16 value shifted up by 16, sign-extended to 64 bits
  function automatic logic signed [63:0] shl16(input logic [31:0] v);
    return {{16{v[31]}}, v, 16'd0};
  endfunction

  function automatic logic signed [32:0] s33(input logic [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [32:0] u33(input logic [31:0] v);
    return {1'b0, v};
  endfunction

endpackage

// ----- src/pffi_div.sv -----
// Iterative signed-by-positive divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps

module pffi_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [47:0]        den,
  output logic               busy,
  output logic signed [63:0] quo
);

  logic [6:0]  cnt;
  logic [47:0] rem;
  logic [47:0] den_r;
  logic [63:0] sh;
  logic        neg;
  logic [48:0] rem_sh;
  logic [48:0] trial;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh = {rem, sh[63]};
    trial  = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt   <= 7'd64;
      sh    <= num[63] ? (~num + 64'd1) : num;
      neg   <= num[63];
      rem   <= '0;
      den_r <= den;
    end else if (cnt != 7'd0) begin
      cnt <= cnt - 7'd1;
      if (!trial[48]) begin
        rem <= trial[47:0];
        sh  <= {sh[62:0], 1'b1};
      end else begin
        rem <= rem_sh[47:0];
        sh  <= {sh[62:0], 1'b0};
      end
    end
  end

  assign busy = (cnt != 7'd0);
  assign quo  = neg ? $signed(~sh + 64'd1) : $signed(sh);

endmodule

// ----- src/pffi_sqrt.sv -----
// Iterative integer square root of a 64-bit value, one result bit per cycle.
`timescale 1ns / 1ps

module pffi_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] sum;

  assign sum = res + bitv;

  // Bit-pair method: test bit walks down two places a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      bitv <= '0;
    end else if (start) begin
      x    <= rad;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (bitv != 64'd0) begin
      if (x >= sum) begin
        x   <= x - sum;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign busy = (bitv != 64'd0);
  assign root = res[31:0];

endmodule

// ----- src/pffi_engine.sv -----
// Engine: particle and field memories, shared multiplier and the item sequencer.
`timescale 1ns / 1ps

module pffi_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pffi_pkg::item_t   item,
  input  pffi_pkg::cfg_t    cfg,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output pffi_pkg::result_t res
);
  import pffi_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE, ST_EXEC, ST_RD, ST_LAT,
    ST_E_VX, ST_E_VY, ST_E_VZ, ST_E_MG, ST_E_KH, ST_E_KL, ST_E_AH, ST_E_AL, ST_E_SUM,
    ST_F_RD, ST_F_LAT, ST_F_SX, ST_F_SY, ST_F_SZ, ST_F_R2, ST_F_CHK, ST_F_NUM, ST_F_WF,
    ST_F_UD, ST_F_UW, ST_F_UM, ST_F_UA, ST_F_NEXT,
    ST_A_D, ST_A_W, ST_A_M1, ST_A_V, ST_A_M2, ST_A_P, ST_WR, ST_DONE
  } state_t;

  state_t              state;
  item_t               itm;
  logic [P_CNT_W-1:0]  part_count;
  logic [F_CNT_W-1:0]  fld_count;
  logic [P_CNT_W-1:0]  pi;
  logic [F_CNT_W-1:0]  fj;
  logic [1:0]          ax;
  p_entry_t            cur;
  logic [2:0][31:0]    d;
  logic [2:0][31:0]    force_sum;
  logic signed [31:0]  fsrc;
  logic signed [31:0]  fstr;
  logic signed [31:0]  fmag;
  logic signed [32:0]  u_q;
  logic signed [31:0]  acc;
  logic [63:0]         r2;
  logic [63:0]         v2;
  logic signed [63:0]  mg;
  logic [63:0]         ke;
  logic [63:0]         mag;
  logic [SLOT_W-1:0]   exec_slot;
  status_t             exec_status;

  // Particle memory: one row per particle
  p_entry_t            pmem [MAX_PARTICLES];
  p_entry_t            p_rdata;
  logic                p_we;
  logic [P_IDX_W-1:0]  p_waddr;
  p_entry_t            p_wdata;

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    p_rdata <= pmem[pi[P_IDX_W-1:0]];
  end

  // Field memory; entry zero is the built-in field and is never written
  f_entry_t            fmem [MAX_FIELDS];
  f_entry_t            f_rdata;
  logic                f_rd_zero;
  logic                f_we;
  f_entry_t            f_row;

  always_ff @(posedge clk) begin
    if (f_we) fmem[fld_count[F_IDX_W-1:0]] <= {itm.field_kind, itm.strength, itm.coord};
    f_rdata   <= fmem[fj[F_IDX_W-1:0]];
    f_rd_zero <= (fj[F_IDX_W-1:0] == '0);
  end

  assign f_row = f_rd_zero ? FLD0_ENTRY : f_rdata;

  // Shared multiplier, product registered
  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  mul_w;
  logic signed [63:0]  mul_p;

  assign mul_w = mul_a * mul_b;

  always_ff @(posedge clk) begin
    mul_p <= mul_w[63:0];
  end

  // Divider and square-root units
  logic               div_start;
  logic signed [63:0] div_num;
  logic [47:0]        div_den;
  logic               div_busy;
  logic signed [63:0] div_q;
  logic               sq_start;
  logic               sq_busy;
  logic [31:0]        sq_root;

  pffi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_q)
  );

  pffi_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (r2),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  // Datapath terms
  logic [31:0]        mpos;
  logic [63:0]        mg_abs;
  logic [32:0]        y_neg;
  logic [31:0]        y_abs;
  logic [63:0]        mag_full;
  logic signed [63:0] pe;
  logic signed [63:0] e_val;
  logic signed [64:0] tot65;
  logic [63:0]        tot_sat;
  logic signed [31:0] src_sel;
  logic               fld_skip;
  logic [2:0][31:0]   d_next;
  logic signed [31:0] comp;
  logic signed [31:0] v_new;
  logic signed [31:0] p_new;
  logic               part_last;

  always_comb begin
    mpos     = cur.mass[31] ? 32'd0 : cur.mass;
    mg_abs   = mg[63] ? 64'(-mg) : 64'(mg);
    y_neg    = -{cur.pos[1][31], cur.pos[1]};
    y_abs    = cur.pos[1][31] ? y_neg[31:0] : cur.pos[1];
    mag_full = mag + {32'd0, mul_p[63:32]};
    pe       = (mg[63] != cur.pos[1][31]) ? -$signed(mag_full) : $signed(mag_full);
    e_val    = $signed(ke) + pe;
    tot65    = {res.total[63], res.total} + {e_val[63], e_val};
    if (tot65[64] != tot65[63]) tot_sat = tot65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else tot_sat = tot65[63:0];

    src_sel  = (f_row.kind == KIND_GRAVITY) ? cur.mass : cur.charge;
    fld_skip = !((f_row.kind == KIND_GRAVITY) || (f_row.kind == KIND_EM)) || (src_sel == 0);
    for (int k = 0; k < 3; k++) begin
      d_next[k] = sat_sub32(f_row.center[k], cur.pos[k]);
    end

    comp  = sat32(div_q16(mul_p));
    v_new = sat32(64'($signed(cur.vel[ax])) + div_q16(mul_p));
    p_new = sat32(64'($signed(cur.pos[ax])) + div_q16(mul_p));
    part_last = ((pi + P_CNT_W'(1)) == part_count);
  end

  // Immediate outcome of the captured request
  always_comb begin
    exec_slot   = '0;
    exec_status = STAT_OK;
    case (itm.req_type)
      REQ_ADD_PART: begin
        if (part_count == P_CNT_W'(MAX_PARTICLES)) exec_status = STAT_FULL;
        else if (itm.mass[31] || itm.mass == 32'd0) exec_status = STAT_MASS;
        else exec_slot = SLOT_W'(part_count);
      end
      REQ_ADD_FIELD: begin
        if (fld_count == F_CNT_W'(MAX_FIELDS)) exec_status = STAT_FULL;
        else exec_slot = SLOT_W'(fld_count);
      end
      REQ_STEP: begin
        if (cfg.paused) exec_status = STAT_PAUSED;
      end
      default: begin end
    endcase
  end

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_E_VX: begin mul_a = s33(cur.vel[0]); mul_b = s33(cur.vel[0]); end
      ST_E_VY: begin mul_a = s33(cur.vel[1]); mul_b = s33(cur.vel[1]); end
      ST_E_VZ: begin mul_a = s33(cur.vel[2]); mul_b = s33(cur.vel[2]); end
      ST_E_MG: begin mul_a = s33(cur.mass); mul_b = s33(cfg.gravity); end
      ST_E_KH: begin mul_a = u33(mpos); mul_b = u33({1'b0, v2[63:33]}); end
      ST_E_KL: begin mul_a = u33(mpos); mul_b = u33({15'd0, v2[32:16]}); end
      ST_E_AH: begin mul_a = u33(mg_abs[63:32]); mul_b = u33(y_abs); end
      ST_E_AL: begin mul_a = u33(mg_abs[31:0]); mul_b = u33(y_abs); end
      ST_F_SX: begin mul_a = s33(d[0]); mul_b = s33(d[0]); end
      ST_F_SY: begin mul_a = s33(d[1]); mul_b = s33(d[1]); end
      ST_F_SZ: begin mul_a = s33(d[2]); mul_b = s33(d[2]); end
      ST_F_CHK: begin mul_a = s33(fstr); mul_b = s33(fsrc); end
      ST_F_UM: begin mul_a = s33(fmag); mul_b = u_q; end
      ST_A_M1: begin mul_a = s33(acc); mul_b = s33(itm.dt); end
      ST_A_M2: begin mul_a = s33(cur.vel[ax]); mul_b = s33(itm.dt); end
      default: begin end
    endcase
  end

  // Memory writes and unit starts
  always_comb begin
    p_we      = 1'b0;
    p_waddr   = pi[P_IDX_W-1:0];
    p_wdata   = cur;
    f_we      = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    case (state)
      ST_EXEC: begin
        if (itm.req_type == REQ_ADD_PART && part_count != P_CNT_W'(MAX_PARTICLES)
            && !itm.mass[31] && itm.mass != 32'd0) begin
          p_we    = 1'b1;
          p_waddr = part_count[P_IDX_W-1:0];
          p_wdata = '{pos: itm.coord, vel: '0, mass: itm.mass, charge: itm.charge};
        end
        if (itm.req_type == REQ_ADD_FIELD && fld_count != F_CNT_W'(MAX_FIELDS)) begin
          f_we = 1'b1;
        end
      end
      ST_F_NUM: begin
        div_start = 1'b1;
        div_num   = mul_p;
        div_den   = r2[63:16];
        sq_start  = 1'b1;
      end
      ST_F_UD: begin
        div_start = 1'b1;
        div_num   = shl16(d[ax]);
        div_den   = {16'd0, sq_root};
      end
      ST_A_D: begin
        div_start = !cur.mass[31] && cur.mass != 32'd0;
        div_num   = shl16(force_sum[ax]);
        div_den   = {16'd0, cur.mass};
      end
      ST_WR: p_we = 1'b1;
      default: begin end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      part_count <= '0;
      fld_count  <= F_CNT_W'(1);
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            itm   <= item;
            state <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          res.slot   <= exec_slot;
          res.total  <= '0;
          res.status <= exec_status;
          pi         <= '0;
          case (itm.req_type)
            REQ_ADD_PART: begin
              if (exec_status == STAT_OK) part_count <= part_count + P_CNT_W'(1);
              state <= ST_DONE;
            end
            REQ_ADD_FIELD: begin
              if (exec_status == STAT_OK) fld_count <= fld_count + F_CNT_W'(1);
              state <= ST_DONE;
            end
            REQ_STEP: begin
              if (cfg.paused || part_count == '0) state <= ST_DONE;
              else state <= ST_RD;
            end
            default: begin
              if (part_count == '0) state <= ST_DONE;
              else state <= ST_RD;
            end
          endcase
        end

        // Particle row fetch
        ST_RD: state <= ST_LAT;
        ST_LAT: begin
          cur       <= p_rdata;
          force_sum <= '0;
          fj        <= '0;
          state     <= (itm.req_type == REQ_ENERGY) ? ST_E_VX : ST_F_RD;
        end

        // Energy of one particle
        ST_E_VX: state <= ST_E_VY;
        ST_E_VY: begin v2 <= mul_p; state <= ST_E_VZ; end
        ST_E_VZ: begin v2 <= v2 + mul_p; state <= ST_E_MG; end
        ST_E_MG: begin v2 <= v2 + mul_p; state <= ST_E_KH; end
        ST_E_KH: begin mg <= mul_p; state <= ST_E_KL; end
        ST_E_KL: begin ke <= mul_p; state <= ST_E_AH; end
        ST_E_AH: begin ke <= ke + {17'd0, mul_p[63:17]}; state <= ST_E_AL; end
        ST_E_AL: begin mag <= mul_p; state <= ST_E_SUM; end
        ST_E_SUM: begin
          res.total <= tot_sat;
          if (part_last) state <= ST_DONE;
          else begin
            pi    <= pi + P_CNT_W'(1);
            state <= ST_RD;
          end
        end

        // Field loop of one particle
        ST_F_RD: state <= ST_F_LAT;
        ST_F_LAT: begin
          fsrc  <= src_sel;
          fstr  <= f_row.strength;
          d     <= d_next;
          state <= fld_skip ? ST_F_NEXT : ST_F_SX;
        end
        ST_F_SX: state <= ST_F_SY;
        ST_F_SY: begin r2 <= mul_p; state <= ST_F_SZ; end
        ST_F_SZ: begin r2 <= r2 + mul_p; state <= ST_F_R2; end
        ST_F_R2: begin r2 <= r2 + mul_p; state <= ST_F_CHK; end
        ST_F_CHK: state <= (r2 <= R2_LIMIT) ? ST_F_NEXT : ST_F_NUM;
        ST_F_NUM: state <= ST_F_WF;
        ST_F_WF: begin
          if (!div_busy && !sq_busy) begin
            fmag  <= sat32(div_q);
            ax    <= '0;
            state <= ST_F_UD;
          end
        end
        ST_F_UD: state <= ST_F_UW;
        ST_F_UW: begin
          if (!div_busy) begin
            u_q   <= div_q[32:0];
            state <= ST_F_UM;
          end
        end
        ST_F_UM: state <= ST_F_UA;
        ST_F_UA: begin
          force_sum[ax] <= sat_add32(force_sum[ax], comp);
          if (ax == 2'd2) state <= ST_F_NEXT;
          else begin
            ax    <= ax + 2'd1;
            state <= ST_F_UD;
          end
        end
        ST_F_NEXT: begin
          if ((fj + F_CNT_W'(1)) == fld_count) begin
            ax    <= '0;
            state <= ST_A_D;
          end else begin
            fj    <= fj + F_CNT_W'(1);
            state <= ST_F_RD;
          end
        end

        // Acceleration, velocity and position per axis
        ST_A_D: begin
          if (cur.mass[31] || cur.mass == 32'd0) begin
            acc   <= '0;
            state <= ST_A_M1;
          end else state <= ST_A_W;
        end
        ST_A_W: begin
          if (!div_busy) begin
            acc   <= sat32(div_q);
            state <= ST_A_M1;
          end
        end
        ST_A_M1: state <= ST_A_V;
        ST_A_V: begin
          cur.vel[ax] <= v_new;
          state       <= ST_A_M2;
        end
        ST_A_M2: state <= ST_A_P;
        ST_A_P: begin
          cur.pos[ax] <= p_new;
          if (ax == 2'd2) state <= ST_WR;
          else begin
            ax    <= ax + 2'd1;
            state <= ST_A_D;
          end
        end
        ST_WR: begin
          if (part_last) state <= ST_DONE;
          else begin
            pi    <= pi + P_CNT_W'(1);
            state <= ST_RD;
          end
        end

        ST_DONE: begin
          if (res_ready) state <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

endmodule

// ----- src/particle_force_field_integrator_core.sv -----
// Top level: request and result channels, configuration registers, result register.
//
//  channel   direction  handshake            payload
//  request   in         req_valid/req_ready  req_type, field_kind, coord_*, mass_in,
//                                            charge_in, strength_in, delta_time
//  result    out        res_valid/res_ready  slot_index, total_energy, status
//  config    in         cfg_we               cfg_index, cfg_data
//
// One request at a time. An energy read takes longer with more particles. A step
// takes longer with more particles and more active fields, set by the bit-serial
// divider (one division for the field strength and three for the unit vector per
// field, three for the acceleration per particle). Reset is synchronous; the
// tables need no clearing pass. A stalled result waits in the result register.
`timescale 1ns / 1ps

module particle_force_field_integrator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         req_type,
  input  logic [1:0]         field_kind,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [31:0] mass_in,
  input  logic signed [31:0] charge_in,
  input  logic signed [31:0] strength_in,
  input  logic signed [31:0] delta_time,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [5:0]         slot_index,
  output logic signed [63:0] total_energy,
  output logic [1:0]         status,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import pffi_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t eng_res;
  logic    eng_idle;
  logic    eng_valid;
  logic    eng_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity <= RESET_GRAVITY;
      cfg.paused  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAVITY: cfg.gravity <= cfg_data;
        CFG_PAUSED:  cfg.paused  <= cfg_data[0];
        default: begin end
      endcase
    end
  end

  assign item = '{
    req_type:   req_type,
    field_kind: field_kind,
    coord:      {coord_z, coord_y, coord_x},
    mass:       mass_in,
    charge:     charge_in,
    strength:   strength_in,
    dt:         delta_time
  };

  assign req_ready = eng_idle;

  pffi_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (req_valid && eng_idle),
    .item      (item),
    .cfg       (cfg),
    .idle      (eng_idle),
    .res_valid (eng_valid),
    .res_ready (eng_ready),
    .res       (eng_res)
  );

  // Result register parts the engine from the result beat
  assign eng_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (eng_ready) begin
      res_valid <= eng_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_ready && eng_valid) begin
      slot_index   <= eng_res.slot;
      total_energy <= eng_res.total;
      status       <= eng_res.status;
    end
  end

endmodule

// ----- src/pffi_checker.sv -----
// Checker: port-level assertions on the integrator core, bound to the top level.
`timescale 1ns / 1ps

module pffi_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic [1:0]         req_type,
  input logic [1:0]         field_kind,
  input logic signed [31:0] coord_x,
  input logic signed [31:0] coord_y,
  input logic signed [31:0] coord_z,
  input logic signed [31:0] mass_in,
  input logic signed [31:0] charge_in,
  input logic signed [31:0] strength_in,
  input logic signed [31:0] delta_time,
  input logic               res_valid,
  input logic               res_ready,
  input logic [5:0]         slot_index,
  input logic signed [63:0] total_energy,
  input logic [1:0]         status,
  input logic               cfg_we,
  input logic               cfg_index,
  input logic [31:0]        cfg_data
);
  import pffi_pkg::*;

  // A stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(slot_index)
      && $stable(total_energy) && $stable(status))
    else $error("result beat changed while stalled");

  // One request in flight: ready drops right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A paused step reports no slot and no energy
  a_paused_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STAT_PAUSED |-> slot_index == 6'd0 && total_energy == 64'sd0)
    else $error("paused step carries data");

endmodule

bind particle_force_field_integrator_core pffi_checker u_chk (.*);
